>>> hw/rtl/fbdpt_pkg.sv
// Package: constants, phase encoding and state type for the four-button debouncer.
package fbdpt_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int TIME_BITS   = 32;
  localparam int SETTLE_BITS = 16;

  // settle time after reset, in milliseconds
  localparam logic [SETTLE_BITS-1:0] SETTLE_RESET = SETTLE_BITS'(40);
  // odd buttons start with their flag set
  localparam logic [NUM_BUTTONS-1:0] FLAG_RESET = NUM_BUTTONS'(8'hAA);

  // per-button debounce phase
  typedef enum logic [1:0] {
    PH_UP      = 2'd0,
    PH_FALLING = 2'd1,
    PH_DOWN    = 2'd2,
    PH_RISING  = 2'd3
  } phase_t;

  // everything that carries from one poll to the next
  typedef struct packed {
    phase_t [NUM_BUTTONS-1:0] phase;
    logic [TIME_BITS-1:0]     timer_start;
    logic [NUM_BUTTONS-1:0]   flags;
    logic                     indicator;
  } fbdpt_state_t;

endpackage

>>> hw/rtl/fbdpt_ifs.sv
// Interfaces: poll word channel and result word channel.
interface fbdpt_in_if
  import fbdpt_pkg::*;
  ;
  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] raw_levels;
  logic [TIME_BITS-1:0]   now_ms;

  modport source (output valid, output raw_levels, output now_ms, input ready);
  modport sink   (input valid, input raw_levels, input now_ms, output ready);
endinterface

interface fbdpt_out_if
  import fbdpt_pkg::*;
  ;
  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] pair_flags;
  logic                   indicator_on;

  modport source (output valid, output pair_flags, output indicator_on, input ready);
  modport sink   (input valid, input pair_flags, input indicator_on, output ready);
endinterface

>>> hw/rtl/fbdpt_update.sv
// Combinational update of all debounce machines, shared timer, flags and indicator.
module fbdpt_update
  import fbdpt_pkg::*;
(
  input  fbdpt_state_t           state_cur,
  input  logic [NUM_BUTTONS-1:0] raw_levels,
  input  logic [TIME_BITS-1:0]   now_ms,
  input  logic [SETTLE_BITS-1:0] settle_ms,
  output fbdpt_state_t           state_nxt
);

  logic [TIME_BITS-1:0]   elapsed;
  logic                   base_pass;
  logic                   settle_zero;
  logic [NUM_BUTTONS-1:0] press;
  logic [NUM_BUTTONS-1:0] release_evt;
  logic                   any_pass;
  phase_t [NUM_BUTTONS-1:0] phase_nxt;
  logic [NUM_BUTTONS-1:0] flags_nxt;
  logic                   ind_nxt;

  // Timer check: the first check in a poll sees the stored start; once one
  // passes the timer restarts at now, so later checks see zero elapsed.
  assign elapsed     = now_ms - state_cur.timer_start;
  assign base_pass   = (elapsed >= TIME_BITS'(settle_ms));
  assign settle_zero = (settle_ms == '0);

  // Phase transitions, walked in button order
  always_comb begin
    logic passed;
    logic chk;
    logic high;
    passed      = 1'b0;
    press       = '0;
    release_evt = '0;
    phase_nxt   = state_cur.phase;
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      high = raw_levels[k];
      chk  = passed ? settle_zero : base_pass;
      case (state_cur.phase[k])
        PH_UP: begin
          if (!high) phase_nxt[k] = PH_FALLING;
        end
        PH_DOWN: begin
          if (high) phase_nxt[k] = PH_RISING;
        end
        PH_FALLING: begin
          if (chk) begin
            passed = 1'b1;
            if (!high) begin
              phase_nxt[k] = PH_DOWN;
              press[k]     = 1'b1;
            end else begin
              phase_nxt[k] = PH_UP;
            end
          end
        end
        default: begin
          if (chk) begin
            passed = 1'b1;
            if (high) begin
              phase_nxt[k]   = PH_UP;
              release_evt[k] = 1'b1;
            end else begin
              phase_nxt[k] = PH_DOWN;
            end
          end
        end
      endcase
    end
    any_pass = passed;
  end

  // Flag toggles and indicator, applied in button order
  always_comb begin
    int partner;
    flags_nxt = state_cur.flags;
    ind_nxt   = state_cur.indicator;
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      partner = k ^ 1;
      if (press[k]) begin
        ind_nxt = 1'b1;
        if (!flags_nxt[k]) begin
          flags_nxt[k] = 1'b1;
          if (partner < NUM_BUTTONS) flags_nxt[partner] = ~flags_nxt[partner];
        end
      end
      if (release_evt[k]) ind_nxt = 1'b0;
    end
  end

  always_comb begin
    state_nxt             = state_cur;
    state_nxt.phase       = phase_nxt;
    state_nxt.flags       = flags_nxt;
    state_nxt.indicator   = ind_nxt;
    state_nxt.timer_start = any_pass ? now_ms : state_cur.timer_start;
  end

endmodule

>>> hw/rtl/four_button_debounce_pair_toggle_top.sv
// Top level: four-button debouncer with pair-toggled selection flags.
//
// Each poll word carries the four raw active-low button levels and the current
// millisecond count; each poll returns one result word with the four selection
// flags and the indicator. The block takes one poll per clock cycle while the
// receiver takes the results. A poll is held in an input register, runs
// through the combinational button update, and its result is then registered
// in the output register once that register is free. The input register and
// the output register together act as a skid: a new poll is taken while a
// result waits, as long as the output register frees up in the same cycle. The
// settle time (cfg_wdata, reset 40 ms) may be written only while no poll is
// in flight.
module four_button_debounce_pair_toggle_top
  import fbdpt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  fbdpt_in_if.sink               in_ch,
  fbdpt_out_if.source            out_ch,
  input  logic                   cfg_we,
  input  logic [SETTLE_BITS-1:0] cfg_wdata
);

  logic [SETTLE_BITS-1:0] settle_r;
  logic                   s1_valid_r;
  logic [NUM_BUTTONS-1:0] s1_levels_r;
  logic [TIME_BITS-1:0]   s1_now_r;
  logic                   out_valid_r;
  fbdpt_state_t           state_r;
  fbdpt_state_t           state_nxt;
  logic                   out_free;
  logic                   step;
  logic                   in_take;

  // Handshake: stage advances when the output register is free
  assign out_free    = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Settle time register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_RESET;
    end else if (cfg_we) begin
      settle_r <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_levels_r <= in_ch.raw_levels;
      s1_now_r    <= in_ch.now_ms;
    end
  end

  fbdpt_update u_update (
    .state_cur  (state_r),
    .raw_levels (s1_levels_r),
    .now_ms     (s1_now_r),
    .settle_ms  (settle_r),
    .state_nxt  (state_nxt)
  );

  // Debounce state; it also serves as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= '{default: PH_UP};
      state_r.timer_start <= '0;
      state_r.flags       <= FLAG_RESET;
      state_r.indicator   <= 1'b0;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pair_flags   = state_r.flags;
  assign out_ch.indicator_on = state_r.indicator;

  // Checks
  a_timer_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(state_r.timer_start))
    else $error("timer start moved without a poll");

  a_flags_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(state_r.flags))
    else $error("flags moved without a poll");

  a_ind_rise_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r.indicator) |-> $past(step))
    else $error("indicator lit without a poll");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("input stalled with an empty stage");

  a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("poll processed but no result shown");

endmodule

>>> sim/fbdpt_checker.sv
// Checker: watches the poll and result channels, predicts each result word and compares.
`timescale 1ns / 100ps
module fbdpt_checker
  import fbdpt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [NUM_BUTTONS-1:0] in_levels,
  input  logic [TIME_BITS-1:0]   in_now,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [NUM_BUTTONS-1:0] out_flags,
  input  logic                   out_ind,
  input  logic                   cfg_we,
  input  logic [SETTLE_BITS-1:0] cfg_wdata,
  output int                     errors,
  output int                     pending,
  output int                     checked,
  output int                     presses,
  output int                     releases
);

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] flags;
    logic                   ind;
  } poll_result_t;

  // predicted debouncer state
  phase_t                 btn_phase [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   settle_start;
  logic [NUM_BUTTONS-1:0] sel_flags;
  logic                   lamp;
  logic [SETTLE_BITS-1:0] settle_ms;

  // result words still owed by the block, oldest first
  poll_result_t pending_results [$];

  // shared settle timer: passes once settle_ms have gone by, then restarts
  function automatic logic settle_passed(input logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] elapsed;
    elapsed = now - settle_start;
    if (elapsed >= TIME_BITS'(settle_ms)) begin
      settle_start = now;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one poll: visit buttons 0..3 in order, queue the word it should produce
  task automatic advance_debounce(input logic [NUM_BUTTONS-1:0] lv,
                                  input logic [TIME_BITS-1:0] now);
    poll_result_t word;
    int           mate;
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      case (btn_phase[k])
        PH_UP: begin
          if (!lv[k]) btn_phase[k] = PH_FALLING;
        end
        PH_DOWN: begin
          if (lv[k]) btn_phase[k] = PH_RISING;
        end
        PH_FALLING: begin
          if (settle_passed(now)) begin
            if (!lv[k]) begin
              btn_phase[k] = PH_DOWN;
              lamp = 1'b1;
              presses++;
              // a press toggles the pair only while its own flag is clear
              if (!sel_flags[k]) begin
                mate = k ^ 1;
                sel_flags[k] = ~sel_flags[k];
                if (mate < NUM_BUTTONS) sel_flags[mate] = ~sel_flags[mate];
              end
            end else begin
              btn_phase[k] = PH_UP;
            end
          end
        end
        default: begin
          if (settle_passed(now)) begin
            if (lv[k]) begin
              btn_phase[k] = PH_UP;
              lamp = 1'b0;
              releases++;
            end else begin
              btn_phase[k] = PH_DOWN;
            end
          end
        end
      endcase
    end
    word.flags = sel_flags;
    word.ind   = lamp;
    pending_results.push_back(word);
  endtask

  always @(posedge clk) begin : watch
    poll_result_t head;
    if (!rst_n) begin
      for (int k = 0; k < NUM_BUTTONS; k++) btn_phase[k] = PH_UP;
      settle_start = '0;
      sel_flags    = FLAG_RESET;
      lamp         = 1'b0;
      settle_ms    = SETTLE_RESET;
      pending_results.delete();
      errors   = 0;
      checked  = 0;
      presses  = 0;
      releases = 0;
    end else begin
      // result side first: it always belongs to an earlier poll
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected: flags=%h ind=%b",
                   $time, out_flags, out_ind);
        end else begin
          head = pending_results.pop_front();
          checked++;
          if (head.flags !== out_flags) begin
            errors++;
            $display("%0t: pair_flags expected %h actual %h", $time, head.flags, out_flags);
          end
          if (head.ind !== out_ind) begin
            errors++;
            $display("%0t: indicator_on expected %b actual %b", $time, head.ind, out_ind);
          end
        end
      end
      if (cfg_we) settle_ms = cfg_wdata;
      if (in_valid && in_ready) advance_debounce(in_levels, in_now);
    end
    pending = pending_results.size();
  end

endmodule

>>> sim/tb.sv
// Testbench top: clock, reset, poll stimulus, receiver stalls, settle-time phases and verdict.
`timescale 1ns / 100ps
module tb;
  import fbdpt_pkg::*;

  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_POLLS = 118;
  localparam int NUM_PHASES  = 8;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [SETTLE_BITS-1:0] cfg_wdata = '0;

  fbdpt_in_if  in_ch ();
  fbdpt_out_if out_ch ();

  int errors, pending, checked, presses, releases;

  // stimulus state
  logic [TIME_BITS-1:0]   clock_ms;
  logic [NUM_BUTTONS-1:0] levels;
  logic [SETTLE_BITS-1:0] settle_cur = SETTLE_RESET;
  int                     snd_idle = 0;
  int                     rcv_stall = 0;
  int                     polls_sent = 0;
  int                     settings_run = 1;
  logic                   hold_req = 1'b0;

  // receiver-owned hold-off bookkeeping
  int   hold_left = 0;
  logic hold_done = 1'b0;

  int idle_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  four_button_debounce_pair_toggle_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  fbdpt_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_levels (in_ch.raw_levels),
    .in_now    (in_ch.now_ms),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_flags (out_ch.pair_flags),
    .out_ind   (out_ch.indicator_on),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .presses   (presses),
    .releases  (releases)
  );

  // result side: random stalls, plus one long hold-off when requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_stall);
      end
    end
  end

  // watchdog: too long with no word moving on either channel
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: %0d cycles with no word accepted", IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // offer one poll word, with random sender gaps ahead of it
  task automatic send_poll(input logic [NUM_BUTTONS-1:0] lv, input logic [TIME_BITS-1:0] t);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.raw_levels <= lv;
    in_ch.now_ms     <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    polls_sent++;
  endtask

  // settle time is only changed with nothing in flight
  task automatic write_settle(input logic [SETTLE_BITS-1:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    settle_cur = v;
    settings_run++;
  endtask

  // mostly plausible button activity: time creeps forward, levels bounce now and then
  task automatic random_poll();
    logic [TIME_BITS-1:0]   step;
    logic [NUM_BUTTONS-1:0] flip;
    if ($urandom_range(99) < 12) begin
      levels   = NUM_BUTTONS'($urandom_range(15));
      clock_ms = $urandom();
    end else begin
      if ($urandom_range(3) == 0) step = settle_cur + $urandom_range(0, settle_cur);
      else step = $urandom_range(0, settle_cur / 3 + 1);
      flip = '0;
      for (int k = 0; k < NUM_BUTTONS; k++)
        if ($urandom_range(7) == 0) flip[k] = 1'b1;
      levels   = levels ^ flip;
      clock_ms = clock_ms + step;
    end
    send_poll(levels, clock_ms);
  endtask

  initial begin
    logic [SETTLE_BITS-1:0] settle_plan [NUM_PHASES];
    in_ch.valid      = 1'b0;
    in_ch.raw_levels = '1;
    in_ch.now_ms     = '0;
    settle_plan = '{SETTLE_RESET, 16'd0, 16'd1, 16'hFFFF, 16'd40, 16'd3, 16'd0, 16'd200};
    settle_plan[6] = SETTLE_BITS'($urandom_range(4, 120));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: press, release, press with flag set, bounces, shared timer, wrap
    send_poll(4'hF, 32'd0);
    send_poll(4'hE, 32'd5);
    send_poll(4'hE, 32'd10);
    send_poll(4'hE, 32'd45);
    send_poll(4'hF, 32'd50);
    send_poll(4'hF, 32'd60);
    send_poll(4'hF, 32'd90);
    send_poll(4'hE, 32'd95);
    send_poll(4'hE, 32'd140);
    send_poll(4'hF, 32'd150);
    send_poll(4'hE, 32'd200);
    send_poll(4'hF, 32'd210);
    send_poll(4'hF, 32'd260);
    send_poll(4'hD, 32'd300);
    send_poll(4'hF, 32'd350);
    send_poll(4'h0, 32'd400);
    send_poll(4'h0, 32'd450);
    send_poll(4'h0, 32'd500);
    send_poll(4'h0, 32'd560);
    send_poll(4'hF, 32'hFFFF_FFF0);
    send_poll(4'hF, 32'h0000_0010);
    send_poll(4'hF, 32'h0000_0030);
    send_poll(4'h0, 32'hFFFF_FFFF);
    send_poll(4'hF, 32'h0000_0000);

    // random phases: each with its own settle time and idle mix
    levels = '1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) write_settle(settle_plan[p]);
      case (p % 4)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 70; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 70; end
        default: begin snd_idle = 26; rcv_stall = 26; end
      endcase
      clock_ms = (p % 2 == 1) ? 32'hFFFF_0000 + $urandom_range(65535) : $urandom();
      // long receiver hold-off while polls keep coming
      if (p == 4) hold_req <= 1'b1;
      for (int i = 0; i < PHASE_POLLS; i++) random_poll();
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d polls over %0d settle settings (0 up to 65535), four idle/stall mixes",
             polls_sent, settings_run);
    $display("Compared %0d result words; %0d presses and %0d releases confirmed",
             checked, presses, releases);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/fbdpt_pkg.sv
hw/rtl/fbdpt_ifs.sv
hw/rtl/fbdpt_update.sv
hw/rtl/four_button_debounce_pair_toggle_top.sv
sim/fbdpt_checker.sv
sim/tb.sv
